// File: src/walk_and_rail_shortest_route_core_assert.svh
// Assertion macros shared by the walk and rail route block.
// Expect clk_i and rst_ni in the including module's scope.
`ifndef WALK_AND_RAIL_SHORTEST_ROUTE_CORE_ASSERT_SVH
`define WALK_AND_RAIL_SHORTEST_ROUTE_CORE_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/wrsr_pkg.sv
// Package of the walk and rail route block: widths, codes, types.
// No dependencies.
`default_nettype none
package wrsr_pkg;
  localparam int unsigned MAX_STATIONS_DEF = 32;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned TIME_W = 40;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DSQ_W = 50;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned QUO_W = 33;
  localparam int unsigned REM_W = 28;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned IDX_CMP_W = 8;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd25;
  localparam logic [STEP_W-1:0] DIV_STEPS = 6'd33;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
  localparam logic REG_WALK = 1'b0;
  localparam logic REG_RAIL = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD_STATION = 2'd0,
    ACT_ADD_LINK    = 2'd1,
    ACT_QUERY       = 2'd2,
    ACT_CLEAR       = 2'd3
  } act_e;

  typedef enum logic {
    UOP_SQRT = 1'b0,
    UOP_DIV  = 1'b1
  } uop_e;

  typedef struct packed {
    logic start;
    uop_e op;
  } unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] value;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QINIT,
    ST_SEL_A,
    ST_SEL_B,
    ST_SEL_DONE,
    ST_U_LD,
    ST_W_CHK,
    ST_W_LD,
    ST_SQX,
    ST_SQY,
    ST_SQRT_GO,
    ST_SQRT_WT,
    ST_DIVW_GO,
    ST_DIVW_WT,
    ST_DIVR_GO,
    ST_DIVR_WT,
    ST_RELAX,
    ST_R_A,
    ST_R_B,
    ST_O_T,
    ST_O_RA,
    ST_O_RB
  } state_e;
endpackage
`default_nettype wire

// File: src/wrsr_if.sv
// Word channels of the walk and rail route block: input and result.
// No dependencies.
`default_nettype none
interface wrsr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] first_x;
  logic signed [23:0] first_y;
  logic signed [23:0] second_x;
  logic signed [23:0] second_y;
  logic [4:0]         link_from;
  logic [4:0]         link_to;
  modport source (output valid, action, first_x, first_y, second_x, second_y,
                  link_from, link_to, input ready);
  modport sink (input valid, action, first_x, first_y, second_x, second_y,
                link_from, link_to, output ready);
endinterface

interface wrsr_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [39:0] travel_time;
  logic [5:0]  route_length;
  logic [4:0]  route_station;
  logic        last;
  modport source (output valid, item_kind, travel_time, route_length, route_station, last,
                  input ready);
  modport sink (input valid, item_kind, travel_time, route_length, route_station, last,
                output ready);
endinterface
`default_nettype wire

// File: src/wrsr_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module wrsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: src/wrsr_cost_unit.sv
// Shared iterative unit: integer square root (2 bits a step) or
// restoring division (1 bit a step). Depends on wrsr_pkg.
`default_nettype none
`include "walk_and_rail_shortest_route_core_assert.svh"
module wrsr_cost_unit
  import wrsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire unit_req_t          req_i,
  input  wire logic [DSQ_W-1:0]   operand_i,
  input  wire logic [SPEED_W-1:0] divisor_i,
  output      unit_rsp_t          rsp_o
);
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  uop_e               op_q, op_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic [DSQ_W-1:0]   val_q, val_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]   res_q, res_d;
  logic [SPEED_W-1:0] div_q, div_d;
  logic [REM_W-1:0]   sq_rem, sq_trial, dv_rem, dv_div;

  always_comb begin
    sq_rem   = {rem_q[REM_W-3:0], val_q[DSQ_W-1 -: 2]};
    sq_trial = {res_q[REM_W-3:0], 2'b01};
    dv_rem   = {rem_q[REM_W-2:0], val_q[DSQ_W-1]};
    dv_div   = {{(REM_W-SPEED_W){1'b0}}, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == UOP_SQRT) ? SQRT_STEPS : DIV_STEPS;
      val_d  = operand_i;
      rem_d  = '0;
      res_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        UOP_SQRT: begin
          val_d = {val_q[DSQ_W-3:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            rem_d = sq_rem - sq_trial;
            res_d = {res_q[QUO_W-2:0], 1'b1};
          end else begin
            rem_d = sq_rem;
            res_d = {res_q[QUO_W-2:0], 1'b0};
          end
        end
        UOP_DIV: begin
          val_d = {val_q[DSQ_W-2:0], 1'b0};
          if (dv_rem >= dv_div) begin
            rem_d = dv_rem - dv_div;
            res_d = {res_q[QUO_W-2:0], 1'b1};
          end else begin
            rem_d = dv_rem;
            res_d = {res_q[QUO_W-2:0], 1'b0};
          end
        end
        default: begin
          val_d = val_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= UOP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    res_q <= res_d;
    div_q <= div_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

  `ASSERT_IMPL(a_no_restart, req_i.start, !busy_q)
  `ASSERT_NEXT(a_done_pulse, done_q, !done_q)
  `ASSERT_IMPL(a_cnt_range, busy_q, (cnt_q != 0) && (cnt_q <= DIV_STEPS))
endmodule
`default_nettype wire

// File: src/walk_and_rail_shortest_route_core.sv
// Top level of the walk and rail route block: sequencer, map storage, APB registers.
// Depends on wrsr_pkg, wrsr_if, wrsr_ram, wrsr_cost_unit.
//
// Use: words on in_i add a station, add a rail link, clear the map or run a query.
// Map words keep the sequencer idle; in_i.ready is high only while it is idle.
// A query runs Dijkstra over the stations plus the start and end points: a min
// scan that reads each node's best time, then per neighbour two squarings, a
// 25-step square root and one or two 33-step divisions in the shared cost unit
// (the second only with a rail link). Last comes the route walk, which reads
// the predecessor of each route station in turn, back from the end point. Results leave
// on out_o: one time word, then one word per route station; last marks the
// final word. The output register lets the next map word be taken while a
// result waits; a stalled receiver holds the sequencer in its output states.
// Reset empties the map and sets both speeds to 256; no clearing pass is
// needed. Speeds are written over APB.
`default_nettype none
`include "walk_and_rail_shortest_route_core_assert.svh"
module walk_and_rail_shortest_route_core
  import wrsr_pkg::*;
#(
  parameter int unsigned MAX_STATIONS = MAX_STATIONS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  wrsr_in_if.sink          in_i,
  wrsr_out_if.source       out_o
);
  localparam int unsigned NODES = MAX_STATIONS + 2;
  localparam int unsigned NDW = $clog2(NODES);
  localparam int unsigned LW = $clog2(MAX_STATIONS);
  localparam int unsigned CW = $clog2(MAX_STATIONS + 1);

  state_e                     state_q, state_d;
  logic [SPEED_W-1:0]         walk_q, walk_d, rail_q, rail_d;
  logic [CW-1:0]              n_q, n_d, len_q, len_d, k_q, k_d;
  logic [MAX_STATIONS-1:0]    links_q [MAX_STATIONS];
  logic [MAX_STATIONS-1:0]    links_d [MAX_STATIONS];
  logic [NODES-1:0]           settled_q, settled_d, reached_q, reached_d;
  logic [NDW-1:0]             i_q, i_d, w_q, w_d, u_q, u_d, cur_q, cur_d;
  logic                       found_q, found_d, ovalid_q, ovalid_d;
  logic                       okind_q, okind_d, olast_q, olast_d;
  logic [TIME_W-1:0]          otime_q, otime_d;
  logic [5:0]                 olen_q, olen_d;
  logic [4:0]                 ostat_q, ostat_d;
  logic signed [COORD_W-1:0]  sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [COORD_W-1:0]  ux_q, ux_d, uy_q, uy_d, wx_q, wx_d, wy_q, wy_d;
  logic [DSQ_W-1:0]           acc_q, acc_d;
  logic [ROOT_W-1:0]          d_q, d_d;
  logic [TIME_W-1:0]          cost_q, cost_d, bu_q, bu_d, bw_q, bw_d;

  logic                       in_acc, ofree, cfg_we, rail_hit, upd, push, eligible;
  logic [NDW-1:0]             s_node, t_node, pred_rd, route_rd;
  logic [2*COORD_W-1:0]       coord_rd;
  logic [TIME_W-1:0]          best_rd, wcost, rcost, cand;
  logic [TIME_W:0]            sum;
  logic signed [COORD_W:0]    dx, dy;
  logic [ROOT_W-1:0]          adx, ady, mul_a;
  logic [DSQ_W-1:0]           prod;
  logic                       coord_we, best_we, pred_we, route_we;
  logic [LW-1:0]              coord_ra;
  logic [NDW-1:0]             best_ra, best_wa;
  logic [TIME_W-1:0]          best_wd;
  logic [NDW-1:0]             pred_wd;
  unit_req_t                  ureq;
  unit_rsp_t                  ursp;
  logic [DSQ_W-1:0]           u_operand;
  logic [SPEED_W-1:0]         u_divisor;
  logic                       link_ok;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      REG_WALK: prdata = {16'd0, walk_q};
      REG_RAIL: prdata = {16'd0, rail_q};
      default:  prdata = '0;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ofree      = !ovalid_q || out_o.ready;
  assign s_node     = NDW'(n_q);
  assign t_node     = s_node + NDW'(1);

  assign out_o.valid         = ovalid_q;
  assign out_o.item_kind     = okind_q;
  assign out_o.travel_time   = otime_q;
  assign out_o.route_length  = olen_q;
  assign out_o.route_station = ostat_q;
  assign out_o.last          = olast_q;

  // distance datapath
  assign dx    = {ux_q[COORD_W-1], ux_q} - {wx_q[COORD_W-1], wx_q};
  assign dy    = {uy_q[COORD_W-1], uy_q} - {wy_q[COORD_W-1], wy_q};
  assign adx   = dx[COORD_W] ? ROOT_W'(-dx) : ROOT_W'(dx);
  assign ady   = dy[COORD_W] ? ROOT_W'(-dy) : ROOT_W'(dy);
  assign mul_a = (state_q == ST_SQX) ? adx : ady;
  assign prod  = {{(DSQ_W-ROOT_W){1'b0}}, mul_a} * {{(DSQ_W-ROOT_W){1'b0}}, mul_a};

  assign ureq.start = (state_q == ST_SQRT_GO) || (state_q == ST_DIVW_GO) ||
                      (state_q == ST_DIVR_GO);
  assign ureq.op    = (state_q == ST_SQRT_GO) ? UOP_SQRT : UOP_DIV;
  assign u_operand  = (state_q == ST_SQRT_GO) ? acc_q : {d_q, 8'd0, 17'd0};
  assign u_divisor  = (state_q == ST_DIVR_GO) ? rail_q : walk_q;

  assign wcost = (walk_q == '0) ? TIME_MAX : TIME_W'(ursp.value);
  assign rcost = (rail_q == '0) ? TIME_MAX : TIME_W'(ursp.value);
  assign sum   = {1'b0, bu_q} + {1'b0, cost_q};
  assign cand  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign upd   = !reached_q[w_q] || (cand < bw_q);

  assign rail_hit = (u_q < s_node) && (w_q < s_node) && links_q[u_q[LW-1:0]][w_q[LW-1:0]];
  assign eligible = reached_q[i_q] && !settled_q[i_q] && (!found_q || (best_rd < bu_q));
  assign push     = (pred_rd != s_node) && (pred_rd < s_node) && (len_q < n_q);
  assign link_ok  = (IDX_CMP_W'(in_i.link_from) < IDX_CMP_W'(n_q)) &&
                    (IDX_CMP_W'(in_i.link_to) < IDX_CMP_W'(n_q));

  // memory ports
  assign coord_we = in_acc && (act_e'(in_i.action) == ACT_ADD_STATION) &&
                    (n_q < CW'(MAX_STATIONS));
  assign coord_ra = (state_q == ST_SEL_DONE) ? u_q[LW-1:0] : w_q[LW-1:0];
  assign best_ra  = (state_q == ST_SEL_A) ? i_q : w_q;
  assign best_we  = (state_q == ST_QINIT) || ((state_q == ST_RELAX) && upd);
  assign best_wa  = (state_q == ST_QINIT) ? s_node : w_q;
  assign best_wd  = (state_q == ST_QINIT) ? '0 : cand;
  assign pred_we  = best_we;
  assign pred_wd  = (state_q == ST_QINIT) ? s_node : u_q;
  assign route_we = (state_q == ST_R_B) && push;

  wrsr_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_STATIONS)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (n_q[LW-1:0]),
    .wdata_i ({in_i.first_x, in_i.first_y}),
    .raddr_i (coord_ra),
    .rdata_o (coord_rd)
  );

  wrsr_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_wa),
    .wdata_i (best_wd),
    .raddr_i (best_ra),
    .rdata_o (best_rd)
  );

  wrsr_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (pred_we),
    .waddr_i (best_wa),
    .wdata_i (pred_wd),
    .raddr_i (cur_q),
    .rdata_o (pred_rd)
  );

  wrsr_ram #(.WIDTH(NDW), .DEPTH(MAX_STATIONS)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (len_q[LW-1:0]),
    .wdata_i (pred_rd),
    .raddr_i (k_q[LW-1:0]),
    .rdata_o (route_rd)
  );

  wrsr_cost_unit u_cost (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ureq),
    .operand_i (u_operand),
    .divisor_i (u_divisor),
    .rsp_o     (ursp)
  );

  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    rail_d    = rail_q;
    n_d       = n_q;
    len_d     = len_q;
    k_d       = k_q;
    links_d   = links_q;
    settled_d = settled_q;
    reached_d = reached_q;
    i_d       = i_q;
    w_d       = w_q;
    u_d       = u_q;
    cur_d     = cur_q;
    found_d   = found_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    okind_d   = okind_q;
    olast_d   = olast_q;
    otime_d   = otime_q;
    olen_d    = olen_q;
    ostat_d   = ostat_q;
    sx_d = sx_q; sy_d = sy_q; ex_d = ex_q; ey_d = ey_q;
    ux_d = ux_q; uy_d = uy_q; wx_d = wx_q; wy_d = wy_q;
    acc_d  = acc_q;
    d_d    = d_q;
    cost_d = cost_q;
    bu_d   = bu_q;
    bw_d   = bw_q;

    if (cfg_we) begin
      case (paddr[2])
        REG_WALK: walk_d = pwdata[SPEED_W-1:0];
        REG_RAIL: rail_d = pwdata[SPEED_W-1:0];
        default:  walk_d = walk_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (act_e'(in_i.action))
            ACT_ADD_STATION: begin
              if (n_q < CW'(MAX_STATIONS)) begin
                n_d = n_q + 1'b1;
              end
            end
            ACT_ADD_LINK: begin
              if (link_ok) begin
                links_d[LW'(in_i.link_from)][LW'(in_i.link_to)] = 1'b1;
                links_d[LW'(in_i.link_to)][LW'(in_i.link_from)] = 1'b1;
              end
            end
            ACT_QUERY: begin
              sx_d    = in_i.first_x;
              sy_d    = in_i.first_y;
              ex_d    = in_i.second_x;
              ey_d    = in_i.second_y;
              len_d   = '0;
              state_d = ST_QINIT;
            end
            ACT_CLEAR: begin
              n_d = '0;
              for (int r = 0; r < MAX_STATIONS; r++) begin
                links_d[r] = '0;
              end
            end
            default: n_d = n_q;
          endcase
        end
      end
      ST_QINIT: begin
        settled_d         = '0;
        reached_d         = '0;
        reached_d[s_node] = 1'b1;
        i_d               = '0;
        found_d           = 1'b0;
        state_d           = ST_SEL_A;
      end
      ST_SEL_A: state_d = ST_SEL_B;
      ST_SEL_B: begin
        if (eligible) begin
          found_d = 1'b1;
          u_d     = i_q;
          bu_d    = best_rd;
        end
        if (i_q == t_node) begin
          state_d = ST_SEL_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_SEL_A;
        end
      end
      ST_SEL_DONE: begin
        if (found_q) begin
          settled_d[u_q] = 1'b1;
        end
        if (!found_q || (u_q == t_node)) begin
          cur_d   = t_node;
          len_d   = '0;
          state_d = ST_R_A;
        end else begin
          state_d = ST_U_LD;
        end
      end
      ST_U_LD: begin
        if (u_q < s_node) begin
          ux_d = coord_rd[2*COORD_W-1:COORD_W];
          uy_d = coord_rd[COORD_W-1:0];
        end else begin
          ux_d = sx_q;
          uy_d = sy_q;
        end
        w_d     = '0;
        state_d = ST_W_CHK;
      end
      ST_W_CHK: begin
        if ((w_q == s_node) || (w_q == u_q) || settled_q[w_q]) begin
          if (w_q == t_node) begin
            i_d     = '0;
            found_d = 1'b0;
            state_d = ST_SEL_A;
          end else begin
            w_d = w_q + 1'b1;
          end
        end else begin
          state_d = ST_W_LD;
        end
      end
      ST_W_LD: begin
        if (w_q < s_node) begin
          wx_d = coord_rd[2*COORD_W-1:COORD_W];
          wy_d = coord_rd[COORD_W-1:0];
        end else begin
          wx_d = ex_q;
          wy_d = ey_q;
        end
        bw_d    = best_rd;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        acc_d   = prod;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        acc_d   = acc_q + prod;
        state_d = ST_SQRT_GO;
      end
      ST_SQRT_GO: state_d = ST_SQRT_WT;
      ST_SQRT_WT: begin
        if (ursp.done) begin
          d_d     = ursp.value[ROOT_W-1:0];
          state_d = ST_DIVW_GO;
        end
      end
      ST_DIVW_GO: state_d = ST_DIVW_WT;
      ST_DIVW_WT: begin
        if (ursp.done) begin
          cost_d  = wcost;
          state_d = rail_hit ? ST_DIVR_GO : ST_RELAX;
        end
      end
      ST_DIVR_GO: state_d = ST_DIVR_WT;
      ST_DIVR_WT: begin
        if (ursp.done) begin
          if (rcost < cost_q) begin
            cost_d = rcost;
          end
          state_d = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (upd) begin
          reached_d[w_q] = 1'b1;
        end
        if (w_q == t_node) begin
          i_d     = '0;
          found_d = 1'b0;
          state_d = ST_SEL_A;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = ST_W_CHK;
        end
      end
      ST_R_A: state_d = ST_R_B;
      ST_R_B: begin
        if (push) begin
          len_d   = len_q + 1'b1;
          cur_d   = pred_rd;
          state_d = ST_R_A;
        end else begin
          state_d = ST_O_T;
        end
      end
      ST_O_T: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          okind_d  = 1'b0;
          otime_d  = bu_q;
          olen_d   = 6'(len_q);
          ostat_d  = '0;
          olast_d  = (len_q == '0);
          if (len_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = len_q - 1'b1;
            state_d = ST_O_RA;
          end
        end
      end
      ST_O_RA: state_d = ST_O_RB;
      ST_O_RB: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          okind_d  = 1'b1;
          otime_d  = '0;
          olen_d   = '0;
          ostat_d  = 5'(route_rd);
          olast_d  = (k_q == '0);
          if (k_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = ST_O_RA;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      walk_q    <= SPEED_RESET;
      rail_q    <= SPEED_RESET;
      n_q       <= '0;
      len_q     <= '0;
      k_q       <= '0;
      for (int r = 0; r < MAX_STATIONS; r++) begin
        links_q[r] <= '0;
      end
      settled_q <= '0;
      reached_q <= '0;
      i_q       <= '0;
      w_q       <= '0;
      u_q       <= '0;
      cur_q     <= '0;
      found_q   <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      rail_q    <= rail_d;
      n_q       <= n_d;
      len_q     <= len_d;
      k_q       <= k_d;
      links_q   <= links_d;
      settled_q <= settled_d;
      reached_q <= reached_d;
      i_q       <= i_d;
      w_q       <= w_d;
      u_q       <= u_d;
      cur_q     <= cur_d;
      found_q   <= found_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    olast_q <= olast_d;
    otime_q <= otime_d;
    olen_q  <= olen_d;
    ostat_q <= ostat_d;
    sx_q <= sx_d; sy_q <= sy_d; ex_q <= ex_d; ey_q <= ey_d;
    ux_q <= ux_d; uy_q <= uy_d; wx_q <= wx_d; wy_q <= wy_d;
    acc_q  <= acc_d;
    d_q    <= d_d;
    cost_q <= cost_d;
    bu_q   <= bu_d;
    bw_q   <= bw_d;
  end

  `ASSERT_IMPL(a_n_bound, 1'b1, n_q <= CW'(MAX_STATIONS))
  `ASSERT_IMPL(a_len_bound, state_q != ST_IDLE, len_q <= n_q)
  `ASSERT_IMPL(a_sel_unsettled, (state_q == ST_SEL_DONE) && found_q, !settled_q[u_q])
  `ASSERT_NEXT(a_unit_busy, ureq.start, ursp.busy)
endmodule
`default_nettype wire

// File: bench/tb_walk_and_rail_shortest_route_core.sv
// Testbench of walk_and_rail_shortest_route_core: map words, queries and APB speed writes,
// with results checked against an in-bench Dijkstra route predictor.
// Depends on wrsr_pkg, wrsr_if and the block itself.
`timescale 1ns / 100ps
module tb_walk_and_rail_shortest_route_core;
  import wrsr_pkg::*;

  typedef struct {
    act_e               act;
    logic signed [23:0] fx, fy, sx, sy;
    logic [4:0]         lf, lt;
  } map_word_t;

  typedef struct {
    logic        kind;
    logic [39:0] ttime;
    logic [5:0]  rlen;
    logic [4:0]  stn;
    logic        last;
  } route_word_t;

  localparam int NST = int'(MAX_STATIONS_DEF);
  localparam longint unsigned TMAX = (64'd1 << 40) - 1;
  localparam int EXP_DEPTH = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wrsr_in_if  in_ch ();
  wrsr_out_if out_ch ();

  walk_and_rail_shortest_route_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [23:0] stn_x [NST];
  logic signed [23:0] stn_y [NST];
  logic [31:0]        links [NST];
  int                 loaded;
  longint unsigned    walk_spd, rail_spd;

  // expected words, ring of EXP_DEPTH
  route_word_t exp_buf [EXP_DEPTH];
  int  exp_wr = 0, exp_rd = 0;
  int  mismatches = 0;
  int  words_sent = 0, queries_run = 0, results_seen = 0;
  bit  idle_on = 1'b1;
  int  rx_hold = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.action = ACT_CLEAR;
    in_ch.first_x = '0; in_ch.first_y = '0; in_ch.second_x = '0; in_ch.second_y = '0;
    in_ch.link_from = '0; in_ch.link_to = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void add_expected(route_word_t e);
    exp_buf[exp_wr % EXP_DEPTH] = e;
    exp_wr++;
  endfunction

  // receiver stalls
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    route_word_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: kind %0d time %0d",
                                       out_ch.item_kind, out_ch.travel_time);
      end else begin
        e = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_ch.item_kind !== e.kind || out_ch.travel_time !== e.ttime ||
            out_ch.route_length !== e.rlen || out_ch.route_station !== e.stn ||
            out_ch.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind %0d time %0d len %0d stn %0d last %0d",
                      " | got %0d %0d %0d %0d %0d"},
                     e.kind, e.ttime, e.rlen, e.stn, e.last, out_ch.item_kind,
                     out_ch.travel_time, out_ch.route_length, out_ch.route_station,
                     out_ch.last);
        end
      end
    end
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned leg_time(longint signed ax, longint signed ay,
                                               longint signed bx, longint signed by,
                                               longint unsigned spd);
    longint signed   dx = ax - bx, dy = ay - by;
    longint unsigned ux, uy, d, t;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    d = int_root(ux * ux + uy * uy);
    if (spd == 0) return TMAX;
    t = (d << 8) / spd;
    return t > TMAX ? TMAX : t;
  endfunction

  task automatic predict_route(map_word_t w);
    longint signed   px [NST+2], py [NST+2];
    longint unsigned best [NST+2];
    int              pred [NST+2];
    bit              reached [NST+2], done [NST+2];
    int              route [NST];
    int n, s, t, u, len;
    bit found;
    longint unsigned c, rc, cand;
    route_word_t e;
    n = loaded; s = n; t = n + 1;
    for (int i = 0; i < n; i++) begin px[i] = stn_x[i]; py[i] = stn_y[i]; end
    px[s] = w.fx; py[s] = w.fy; px[t] = w.sx; py[t] = w.sy;
    for (int i = 0; i < NST + 2; i++) begin
      reached[i] = 0; done[i] = 0; best[i] = 0; pred[i] = 0;
    end
    reached[s] = 1; pred[s] = s;
    forever begin
      found = 0; u = 0;
      for (int i = 0; i <= t; i++)
        if (reached[i] && !done[i] && (!found || best[i] < best[u])) begin
          u = i; found = 1;
        end
      if (!found) break;
      done[u] = 1;
      if (u == t) break;
      for (int v = 0; v <= t; v++) begin
        if (v == s || v == u || done[v]) continue;
        c = leg_time(px[u], py[u], px[v], py[v], walk_spd);
        if (u < n && v < n && links[u][v]) begin
          rc = leg_time(px[u], py[u], px[v], py[v], rail_spd);
          if (rc < c) c = rc;
        end
        cand = best[u] + c;
        if (cand > TMAX) cand = TMAX;
        if (!reached[v] || cand < best[v]) begin
          reached[v] = 1; best[v] = cand; pred[v] = u;
        end
      end
    end
    len = 0; u = pred[t];
    while (u != s && u < n && len < n) begin
      route[len++] = u;
      u = pred[u];
    end
    e.kind = 1'b0; e.ttime = best[t][39:0]; e.rlen = 6'(len); e.stn = '0;
    e.last = (len == 0);
    add_expected(e);
    for (int i = 0; i < len; i++) begin
      e.kind = 1'b1; e.ttime = '0; e.rlen = '0; e.stn = 5'(route[len-1-i]);
      e.last = (i + 1 == len);
      add_expected(e);
    end
  endtask

  task automatic apply_word(map_word_t w);
    case (w.act)
      ACT_ADD_STATION: if (loaded < NST) begin
        stn_x[loaded] = w.fx; stn_y[loaded] = w.fy; loaded++;
      end
      ACT_ADD_LINK: if (w.lf < loaded && w.lt < loaded) begin
        links[w.lf][w.lt] = 1'b1; links[w.lt][w.lf] = 1'b1;
      end
      ACT_CLEAR: begin
        loaded = 0;
        foreach (links[i]) links[i] = '0;
      end
      default: begin
        queries_run++;
        predict_route(w);
      end
    endcase
  endtask

  task automatic send_word(map_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid = 1'b1; in_ch.action = w.act;
    in_ch.first_x = w.fx; in_ch.first_y = w.fy;
    in_ch.second_x = w.sx; in_ch.second_y = w.sy;
    in_ch.link_from = w.lf; in_ch.link_to = w.lt;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
    apply_word(w);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    drop_valid();
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_speed(logic idx, logic [15:0] val);
    wait_idle();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = {16'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_WALK) walk_spd = 64'(val); else rail_spd = 64'(val);
  endtask

  function automatic logic signed [23:0] any_coord(bit wide);
    if (wide) return 24'($urandom());
    return 24'($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic map_word_t mk(act_e a, int fx, int fy, int sx, int sy,
                                   int lf, int lt);
    map_word_t w;
    w.act = a; w.fx = 24'(fx); w.fy = 24'(fy); w.sx = 24'(sx); w.sy = 24'(sy);
    w.lf = 5'(lf); w.lt = 5'(lt);
    return w;
  endfunction

  task automatic test_directed();
    send_word(mk(ACT_QUERY, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 0, 0));
    send_word(mk(ACT_ADD_STATION, 24'sh000000, 24'sh000000, 24'shFFFFFF, 0, 31, 31));
    send_word(mk(ACT_ADD_STATION, 24'sh7FFFFF, 24'sh7FFFFF, 0, 24'sh800000, 0, 0));
    send_word(mk(ACT_ADD_STATION, 24'sh800000, 24'sh800000, 0, 0, 0, 0));
    send_word(mk(ACT_ADD_STATION, 24'sh000400, 24'sh000000, 0, 0, 0, 0));
    send_word(mk(ACT_ADD_LINK, 0, 0, 0, 0, 0, 3));
    send_word(mk(ACT_ADD_LINK, 0, 0, 0, 0, 2, 2));
    send_word(mk(ACT_ADD_LINK, 0, 0, 0, 0, 1, 4));
    send_word(mk(ACT_ADD_LINK, 0, 0, 0, 0, 31, 0));
    send_word(mk(ACT_QUERY, 24'shFFFF00, 0, 24'sh000500, 0, 0, 0));
    send_word(mk(ACT_QUERY, 24'sh000100, 0, 24'sh000100, 0, 0, 0));
    send_word(mk(ACT_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 0, 0));
    write_speed(REG_WALK, 16'd1);
    write_speed(REG_RAIL, 16'hFFFF);
    send_word(mk(ACT_QUERY, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 0, 0));
    send_word(mk(ACT_QUERY, 24'sh000010, 24'sh000000, 24'sh000400, 24'sh000001, 0, 0));
    send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(mk(ACT_QUERY, 0, 0, 24'sh001000, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_full_map();
    write_speed(REG_WALK, 16'd1);
    write_speed(REG_RAIL, 16'hFFFF);
    send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < NST + 1; i++)
      send_word(mk(ACT_ADD_STATION, i * 24'sh000800, 24'sh000040 * (i % 2), 0, 0, 0, 0));
    for (int i = 0; i < NST - 1; i++)
      send_word(mk(ACT_ADD_LINK, 0, 0, 0, 0, i, i + 1));
    send_word(mk(ACT_QUERY, 24'shFFFF00, 0, 24'sh010000, 24'sh000040, 0, 0));
    wait_idle();
  endtask

  task automatic test_random(int budget);
    int k, ns;
    bit wide;
    logic [15:0] spd [6] = '{16'd1, 16'hFFFF, 16'd256, 16'd0, 16'd0, 16'd0};
    k = 0;
    while (k < budget) begin
      spd[3] = 16'($urandom_range(1, 65535)); spd[4] = 16'($urandom_range(1, 2048));
      spd[5] = 16'($urandom_range(1, 65535));
      write_speed(REG_WALK, spd[$urandom_range(0, 5)]);
      write_speed(REG_RAIL, spd[$urandom_range(0, 5)]);
      if (k > budget * 3 / 4) idle_on = 1'b0;
      wide = ($urandom_range(0, 4) == 0);
      send_word(mk(ACT_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom()));
      ns = $urandom_range(2, 6);
      for (int i = 0; i < ns; i++)
        send_word(mk(ACT_ADD_STATION, any_coord(wide), any_coord(wide), $urandom(),
                     $urandom(), $urandom(), $urandom()));
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0)
          send_word(mk(ACT_ADD_LINK, $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom()));
        else
          send_word(mk(ACT_ADD_LINK, $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom_range(0, ns - 1), $urandom_range(0, ns - 1)));
      end
      repeat ($urandom_range(1, 3)) begin
        send_word(mk(ACT_QUERY, any_coord(wide), any_coord(wide), any_coord(wide),
                     any_coord(wide), $urandom(), $urandom()));
        if ($urandom_range(0, 2) == 0)
          send_word(mk(ACT_ADD_STATION, any_coord(wide), any_coord(wide), $urandom(),
                       $urandom(), $urandom(), $urandom()));
      end
      k = words_sent;
    end
    wait_idle();
  endtask

  initial begin
    walk_spd = 64'(SPEED_RESET); rail_spd = 64'(SPEED_RESET); loaded = 0;
    foreach (links[i]) links[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_map();
    test_random(140);
    repeat (50) @(negedge clk_i);
    $display("Sent %0d words, ran %0d route queries, checked %0d result words.",
             words_sent, queries_run, results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout, %0d words still expected", exp_wr - exp_rd);
    $display("Some tests failed");
    $finish;
  end
endmodule
